>>> rtl/core/quadratic_interpolation_resampler_core_defines.svh
// Assertion macros shared by the resampler RTL.
`ifndef QUADRATIC_INTERPOLATION_RESAMPLER_CORE_DEFINES_SVH
`define QUADRATIC_INTERPOLATION_RESAMPLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define QIR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define QIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define QIR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/qir_pkg.sv
package qir_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 8;
    localparam int CNT_W       = 11;
    localparam int IDX_W       = 10;
    localparam int NUM_W       = 20;
    localparam int T_BITS      = 16;
    localparam int QUO_W       = NUM_W + T_BITS;
    localparam int DIV_STEPS   = QUO_W;
    localparam int VALUE_W     = 22;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic REG_IN_COUNT  = 1'b0;
    localparam logic REG_OUT_COUNT = 1'b1;

    // Item handed from front to back
    typedef struct packed {
        logic               act;
        logic [ADDR_W-1:0]  idx;
        logic [SAMPLE_BITS-1:0] sval;
        logic [NUM_W-1:0]   num;
    } qir_item_t;

    // Clamped configuration
    typedef struct packed {
        logic [ADDR_W-1:0] nim1;
        logic [CNT_W-1:0]  den;
    } qir_cfg_t;

    // One divider step
    typedef struct packed {
        logic               act;
        logic [ADDR_W-1:0]  idx;
        logic [SAMPLE_BITS-1:0] sval;
        logic [NUM_W-1:0]   dvd;
        logic [CNT_W-1:0]   rem;
        logic [QUO_W-1:0]   quo;
    } qir_div_t;

endpackage

>>> rtl/core/qir_ram.sv
module qir_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/qir_front.sv
module qir_front import qir_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  qir_cfg_t        cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,
    input  logic            s_tuser,
    output logic            q_push,
    input  logic            q_ready,
    output qir_item_t       q_item
);

    logic      f_valid_reg;
    qir_item_t f_item_reg;
    qir_item_t f_item_next;
    logic      take;

    assign s_tready = !f_valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;
    assign q_push   = f_valid_reg;
    assign q_item   = f_item_reg;

    // unpack request and form i*(in_count-1)
    always_comb begin
        f_item_next.act  = s_tuser;
        f_item_next.idx  = s_tdata[ADDR_W-1:0];
        f_item_next.sval = s_tdata[ADDR_W+SAMPLE_BITS-1:ADDR_W];
        f_item_next.num  = NUM_W'(s_tdata[ADDR_W+SAMPLE_BITS+IDX_W-1:ADDR_W+SAMPLE_BITS]
                                  * cfg.nim1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (take) begin
            f_valid_reg <= 1'b1;
        end else if (q_ready) begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_item_reg <= f_item_next;
        end
    end

endmodule

>>> rtl/core/qir_queue.sv
module qir_queue import qir_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    output logic      push_ready,
    input  qir_item_t push_item,
    output logic      pop_valid,
    input  logic      pop,
    output qir_item_t pop_item
);

    qir_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign pop_valid  = (count_reg != '0);
    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH)) || pop;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/qir_back.sv
module qir_back import qir_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  qir_cfg_t           cfg,
    input  logic               q_valid,
    input  qir_item_t          q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_value,
    output logic               m_held
);

    logic advance;

    // divider pipeline
    logic             dv_valid_reg [DIV_STEPS];
    qir_div_t         dv_reg  [DIV_STEPS];
    qir_div_t         dv_src  [DIV_STEPS];
    qir_div_t         dv_next [DIV_STEPS];
    logic [CNT_W:0]   dv_part [DIV_STEPS];
    logic [CNT_W:0]   dv_diff [DIV_STEPS];

    // stage D (divider result)
    qir_div_t            d_item;
    logic                d_valid;
    logic [NUM_W-1:0]    d_x0;
    logic [T_BITS-1:0]   d_t;
    logic                d_edge;
    logic [T_BITS:0]     d_um;
    logic [T_BITS+1:0]   d_vm;
    logic                wr_en;
    logic [ADDR_W-1:0]   ra0, ra1, ra2;
    logic [SAMPLE_BITS-1:0] y0, y1, y2;

    // stage A
    logic              a_valid_reg;
    logic              a_act_reg, a_edge_reg;
    logic [34:0]       a_pa_reg;
    logic [33:0]       a_pb_reg;
    logic [32:0]       a_pc_reg;
    logic [16:0]       w0, w1;
    logic signed [33:0] w2_full;
    logic signed [17:0] w2;

    // stage B
    logic              b_valid_reg;
    logic              b_act_reg, b_edge_reg;
    logic [SAMPLE_BITS-1:0] b_y0_reg;
    logic [28:0]       b_m0_reg, b_m1_reg;
    logic signed [30:0] b_m2_reg;
    logic signed [31:0] b_sum;
    logic signed [31:0] b_round;

    // output register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_held_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign q_pop    = advance && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_held   = out_held_reg;

    // one quotient bit per step, restoring
    always_comb begin
        dv_src[0]      = '0;
        dv_src[0].act  = q_item.act;
        dv_src[0].idx  = q_item.idx;
        dv_src[0].sval = q_item.sval;
        dv_src[0].dvd  = q_item.num;
        for (int k = 1; k < DIV_STEPS; k++) begin
            dv_src[k] = dv_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            dv_part[k]      = {dv_src[k].rem, dv_src[k].dvd[NUM_W-1]};
            dv_diff[k]      = dv_part[k] - {1'b0, cfg.den};
            dv_next[k]      = dv_src[k];
            dv_next[k].dvd  = {dv_src[k].dvd[NUM_W-2:0], 1'b0};
            if (dv_part[k] >= {1'b0, cfg.den}) begin
                dv_next[k].rem = dv_diff[k][CNT_W-1:0];
                dv_next[k].quo = {dv_src[k].quo[QUO_W-2:0], 1'b1};
            end else begin
                dv_next[k].rem = dv_part[k][CNT_W-1:0];
                dv_next[k].quo = {dv_src[k].quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_STEPS; k++) dv_valid_reg[k] <= 1'b0;
        end else if (advance) begin
            dv_valid_reg[0] <= q_valid;
            for (int k = 1; k < DIV_STEPS; k++) dv_valid_reg[k] <= dv_valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < DIV_STEPS; k++) dv_reg[k] <= dv_next[k];
        end
    end

    // stage D: edge test, store access, weight products
    assign d_item  = dv_reg[DIV_STEPS-1];
    assign d_valid = dv_valid_reg[DIV_STEPS-1];
    assign d_x0    = d_item.quo[QUO_W-1:T_BITS];
    assign d_t     = d_item.quo[T_BITS-1:0];
    assign d_edge  = (({1'b0, d_x0} + (NUM_W+1)'(1)) >= (NUM_W+1)'(cfg.nim1));
    assign d_um    = {1'b1, {T_BITS{1'b0}}} - {1'b0, d_t};
    assign d_vm    = {2'b10, {T_BITS{1'b0}}} - {2'b00, d_t};
    assign wr_en   = advance && d_valid && (d_item.act == ACT_WRITE);
    assign ra0     = d_edge ? cfg.nim1 : d_x0[ADDR_W-1:0];
    assign ra1     = d_x0[ADDR_W-1:0] + ADDR_W'(1);
    assign ra2     = d_x0[ADDR_W-1:0] + ADDR_W'(2);

    // three copies of the store, one per tap
    qir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram0 (
        .aclk(aclk), .we(wr_en), .waddr(d_item.idx), .wdata(d_item.sval),
        .re(advance), .raddr(ra0), .rdata(y0)
    );
    qir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram1 (
        .aclk(aclk), .we(wr_en), .waddr(d_item.idx), .wdata(d_item.sval),
        .re(advance), .raddr(ra1), .rdata(y1)
    );
    qir_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram2 (
        .aclk(aclk), .we(wr_en), .waddr(d_item.idx), .wdata(d_item.sval),
        .re(advance), .raddr(ra2), .rdata(y2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_act_reg  <= d_item.act;
            a_edge_reg <= d_edge;
            a_pa_reg   <= 35'(d_um * d_vm);
            a_pb_reg   <= 34'(d_t * d_vm);
            a_pc_reg   <= 33'(d_t * d_um);
        end
    end

    // stage A: round the weights, multiply by the samples
    assign w0      = 17'((36'(a_pa_reg) + 36'd65536) >> 17);
    assign w1      = 17'((35'(a_pb_reg) + 35'd32768) >> 16);
    assign w2_full = 34'sd65536 - $signed({1'b0, a_pc_reg});
    assign w2      = 18'(w2_full >>> 17);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_act_reg  <= a_act_reg;
            b_edge_reg <= a_edge_reg;
            b_y0_reg   <= y0;
            b_m0_reg   <= 29'(y0 * w0);
            b_m1_reg   <= 29'(y1 * w1);
            b_m2_reg   <= 31'($signed({1'b0, y2}) * w2);
        end
    end

    // stage B: sum and round to the output fraction
    assign b_sum   = $signed({3'b000, b_m0_reg}) + $signed({3'b000, b_m1_reg})
                   + 32'(b_m2_reg);
    assign b_round = (b_sum + 32'sd128) >>> (T_BITS - FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= b_valid_reg && (b_act_reg == ACT_REQUEST);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_held_reg <= b_edge_reg;
            if (b_edge_reg) begin
                out_value_reg <= VALUE_W'({b_y0_reg, {FRAC_BITS{1'b0}}});
            end else begin
                out_value_reg <= b_round[VALUE_W-1:0];
            end
        end
    end

endmodule

>>> rtl/core/quadratic_interpolation_resampler_core.sv
// Channel   Dir  Handshake            Contents
// s_        in   s_tvalid/s_tready    tdata: sample_index, sample_value, output_index
//                                     tuser: action
// m_        out  m_tvalid/m_tready    tdata: value; tuser: held_last
// cfg_      in   cfg_wr_en            index 0 in_count, 1 out_count
//
// One item is taken per cycle while the queue has room; a request passes the
// front register, a queue slot, the 36-step pipelined divider, weight stage
// with the store read, sample multiply stage and the output register. Writes
// pass the same pipe. Reset is synchronous and clears only control state; the
// store is not cleared. A stalled output freezes the back pipe; the front keeps
// filling the queue.
`include "quadratic_interpolation_resampler_core_defines.svh"
module quadratic_interpolation_resampler_core import qir_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [9:0] sample_index, [21:10] sample_value,
                                    // [31:22] output_index
    input  logic         s_tuser,   // [0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // [21:0] value, [23:22] zero
    output logic         m_tuser,   // [0] held_last
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [10:0]  cfg_wdata
);

    logic [CNT_W-1:0]   in_count_reg, out_count_reg;
    qir_cfg_t           cfg;
    logic               q_push, q_ready, q_valid, q_pop;
    qir_item_t          q_in, q_out;
    logic [VALUE_W-1:0] value;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_count_reg  <= CNT_W'(MAX_SAMPLES);
            out_count_reg <= CNT_W'(MAX_SAMPLES);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IN_COUNT:  in_count_reg  <= cfg_wdata;
                REG_OUT_COUNT: out_count_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // clamp to the usable range
    always_comb begin
        priority if (in_count_reg == '0) begin
            cfg.nim1 = '0;
        end else if (in_count_reg > CNT_W'(MAX_SAMPLES)) begin
            cfg.nim1 = ADDR_W'(MAX_SAMPLES - 1);
        end else begin
            cfg.nim1 = ADDR_W'(in_count_reg - 1'b1);
        end
        if (out_count_reg < CNT_W'(2)) begin
            cfg.den = CNT_W'(1);
        end else begin
            cfg.den = out_count_reg - 1'b1;
        end
    end

    qir_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_push(q_push), .q_ready(q_ready), .q_item(q_in)
    );

    qir_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_ready(q_ready), .push_item(q_in),
        .pop_valid(q_valid), .pop(q_pop), .pop_item(q_out)
    );

    qir_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .q_valid(q_valid), .q_item(q_out), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_value(value), .m_held(m_tuser)
    );

    assign m_tdata = {2'b00, value};

    // checks
    `QIR_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `QIR_ASSERT(a_stall_freezes_back, aclk, aresetn, (m_tvalid && !m_tready) |-> !q_pop, "queue popped while output stalled")
    `QIR_ASSERT(a_edge_value_range, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata[23:20] == 4'b0000), "held value too wide")

endmodule
